>>> rtl/md5_pkg.sv
// md5 hash engine shared definitions: field widths, action codes, round tables
// and the per-round helper functions. no dependencies.
`default_nettype none

package md5_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int WIDX_W   = 2;
    localparam int LEN_W    = 61;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ABSORB  = 2'd0,
        ACT_FINISH  = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_PEEK    = 2'd3
    } t_action;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;
    localparam logic [5:0]        LEN_POS  = 6'd56;

    localparam logic [WORD_W-1:0] H_INIT [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    localparam logic [WORD_W-1:0] K_TAB [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    localparam logic [4:0] S_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a round
    function automatic logic [3:0] md5_g(input logic [5:0] rnd);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            default: g = 4'(i4 * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [WORD_W-1:0] md5_f(
        input logic [1:0]        q,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] f;
        case (q)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] md5_rotl(
        input logic [WORD_W-1:0] v,
        input logic [4:0]        s
    );
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} << s;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/md5_in_if.sv
// input channel of the md5 engine: valid/ready with action and message byte.
// depends on md5_pkg for field widths.
`default_nettype none

interface md5_in_if
    import md5_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/md5_out_if.sv
// output channel of the md5 engine: valid/ready with one chaining word per beat.
// depends on md5_pkg for field widths.
`default_nettype none

interface md5_out_if
    import md5_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word;
    logic [WIDX_W-1:0] word_index;
    logic              last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

`default_nettype wire

>>> rtl/md5_hash_engine_core.sv
// md5 engine: absorb stores one byte; a byte filling the block starts a compression
// (read prefetch, 64 rounds at one round per cycle, chaining add); no input is taken
// until it ends. finish: (64 - fill) padding writes, 64 more writes when the length
// spills into a second block, one or two compressions, then 4 output beats. peek: 4
// output beats. one item at a time. reset (synchronous, active low) loads the initial
// chaining words and zeroes fill count and length; the buffer is not cleared
`default_nettype none

module md5_hash_engine_core
    import md5_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    md5_in_if.sink     i_in,
    md5_out_if.source  o_out
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PAD  = 6'b000010,
        ST_PRE  = 6'b000100,
        ST_COMP = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_h [4];
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d;
    logic [5:0]        r_fill;
    logic [LEN_W-1:0]  r_len;
    logic [5:0]        r_round;
    logic [5:0]        r_pos;
    logic              r_first;
    logic              r_need2;
    logic              r_fin;
    logic [WIDX_W-1:0] r_emit_idx;

    // block buffer: 16 message words, byte-lane writes, registered read
    logic [WORD_W-1:0] mem [16];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [5:0]        mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [3:0]        mem_raddr;

    logic              in_fire;
    logic              out_fire;
    t_action           act;
    logic [63:0]       bit_len;
    logic [BYTE_W-1:0] len_byte;
    logic [BYTE_W-1:0] pad_byte;
    logic [5:0]        next_round;
    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] t_val;
    logic [WORD_W-1:0] b_new;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign act      = t_action'(i_in.action);

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_EMIT);
    assign o_out.digest_word = r_h[r_emit_idx];
    assign o_out.word_index  = r_emit_idx;
    assign o_out.last_word   = (r_emit_idx == WIDX_W'(3));

    // padding byte: marker, zeros, then the little-endian bit length
    assign bit_len  = {r_len, 3'b000};
    assign len_byte = bit_len[{r_pos[2:0], 3'b000} +: BYTE_W];
    assign pad_byte = r_first ? PAD_BYTE :
                      (!r_need2 && r_pos >= LEN_POS) ? len_byte : '0;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = pad_byte;
        if (r_state == ST_PAD) begin
            mem_we = 1'b1;
        end else if (in_fire && act == ACT_ABSORB) begin
            mem_we    = 1'b1;
            mem_waddr = r_fill;
            mem_wdata = i_in.data_byte;
        end
    end

    // fetch one round ahead to cover the read latency
    assign next_round = r_round + 6'd1;
    assign mem_raddr  = (r_state == ST_COMP) ? md5_g(next_round) : md5_g(6'd0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr[5:2]][{mem_waddr[1:0], 3'b000} +: BYTE_W] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign f_val = md5_f(r_round[5:4], r_b, r_c, r_d);
    assign t_val = r_a + f_val + r_rdata + K_TAB[r_round];
    assign b_new = r_b + md5_rotl(t_val, S_TAB[{r_round[5:4], r_round[1:0]}]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_h        <= H_INIT;
            r_fill     <= '0;
            r_len      <= '0;
            r_round    <= '0;
            r_pos      <= '0;
            r_first    <= 1'b0;
            r_need2    <= 1'b0;
            r_fin      <= 1'b0;
            r_emit_idx <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        unique case (act)
                            ACT_ABSORB: begin
                                r_fill <= r_fill + 6'd1;
                                r_len  <= r_len + LEN_W'(1);
                                if (r_fill == 6'd63) begin
                                    r_fin   <= 1'b0;
                                    r_state <= ST_PRE;
                                end
                            end
                            ACT_FINISH: begin
                                r_pos   <= r_fill;
                                r_first <= 1'b1;
                                r_need2 <= (r_fill >= LEN_POS);
                                r_fin   <= 1'b1;
                                r_state <= ST_PAD;
                            end
                            ACT_RESTART: begin
                                r_h    <= H_INIT;
                                r_fill <= '0;
                                r_len  <= '0;
                            end
                            ACT_PEEK: begin
                                r_fin      <= 1'b0;
                                r_emit_idx <= '0;
                                r_state    <= ST_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PAD: begin
                    r_first <= 1'b0;
                    r_pos   <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    r_a     <= r_h[0];
                    r_b     <= r_h[1];
                    r_c     <= r_h[2];
                    r_d     <= r_h[3];
                    r_round <= '0;
                    r_state <= ST_COMP;
                end
                ST_COMP: begin
                    r_a     <= r_d;
                    r_d     <= r_c;
                    r_c     <= r_b;
                    r_b     <= b_new;
                    r_round <= next_round;
                    if (r_round == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    if (!r_fin) begin
                        r_state <= ST_IDLE;
                    end else if (r_need2) begin
                        // length goes into a second block
                        r_need2 <= 1'b0;
                        r_pos   <= '0;
                        r_state <= ST_PAD;
                    end else begin
                        r_emit_idx <= '0;
                        r_state    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_fire) begin
                        r_emit_idx <= r_emit_idx + WIDX_W'(1);
                        if (r_emit_idx == WIDX_W'(3)) begin
                            if (r_fin) begin
                                r_h    <= H_INIT;
                                r_fill <= '0;
                                r_len  <= '0;
                                r_fin  <= 1'b0;
                            end
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("output beat pending while input is open");

    a_absorb_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && !r_fin) |=> (r_fill == 6'd0))
        else $error("fill count not empty after block compression");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && r_round == 6'd63) |=> (r_state == ST_ADD))
        else $error("compression did not end after the last round");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.last_word) |=> (r_state == ST_IDLE && r_emit_idx == '0))
        else $error("engine not idle after the last digest beat");

endmodule

`default_nettype wire
